// ===== rtl/core/encspi_pkg.sv =====
// Shared types and constants for the encoder SPI response checker.
// Depends on nothing; every other file of the block refers to it by scoped names.

package encspi_pkg;

  // Widths of the frame bytes, the position words and the failure count.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FRAC_BITS  = 18;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned DROP_W     = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned KEPT_W     = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_VARIANT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION_DROP = 1'b1;

  // Frame variants and response kinds.
  localparam logic VARIANT_16 = 1'b0;
  localparam logic VARIANT_24 = 1'b1;
  localparam logic KIND_POSITION = 1'b0;
  localparam logic KIND_REGISTER = 1'b1;

  // CRC-6 over the register data byte: MSB first, no final XOR.
  localparam logic [5:0] CRC6_POLY = 6'h04;
  localparam logic [5:0] CRC6_INIT = 6'h04;

  // Saturation value of the failure counter.
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_PARITY = 2'd1,
    FAULT_DEVICE = 2'd2,
    FAULT_CRC    = 2'd3
  } fault_t;

  // Outcome of the frame check, handed to the position scaler and the top level.
  typedef struct packed {
    logic                  frame_ok;
    fault_t                fault;
    logic                  pos_ok;
    logic [FRAC_BITS-1:0]  raw_pos;
    logic [BYTE_W-1:0]     register_value;
    logic                  alert_flag;
    logic                  count_fail;
  } chk_t;

  // One result word as held in the output register.
  typedef struct packed {
    logic                  frame_ok;
    fault_t                fault;
    logic [FRAC_BITS-1:0]  position;
    logic [FRAC_BITS-1:0]  turn_fraction;
    logic [BYTE_W-1:0]     register_value;
    logic                  alert_flag;
    logic [CNT_W-1:0]      failure_total;
  } res_t;

  // Bitwise CRC-6 over one byte, eight shift steps on a six-bit value.
  function automatic logic [5:0] crc6_byte(input logic [BYTE_W-1:0] data);
    logic [5:0] crc;
    logic       fb;
    crc = CRC6_INIT;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb  = crc[5] ^ data[i];
      crc = {crc[4:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC6_POLY;
      end
    end
    return crc;
  endfunction

endpackage

// ===== rtl/core/encspi_in_if.sv =====
// Input channel carrying one received response frame per word.
// Depends on encspi_pkg for the byte width.

interface encspi_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [encspi_pkg::BYTE_W-1:0] first_byte;
  logic [encspi_pkg::BYTE_W-1:0] second_byte;
  logic [encspi_pkg::BYTE_W-1:0] third_byte;

  modport source (output valid, kind, first_byte, second_byte, third_byte, input ready);
  modport sink   (input valid, kind, first_byte, second_byte, third_byte, output ready);
endinterface

// ===== rtl/core/encspi_out_if.sv =====
// Result channel carrying the checked and unpacked frame.
// Depends on encspi_pkg for field widths.

interface encspi_out_if;
  logic                             valid;
  logic                             ready;
  logic                             frame_ok;
  logic [1:0]                       fault;
  logic [encspi_pkg::FRAC_BITS-1:0] position;
  logic [encspi_pkg::FRAC_BITS-1:0] turn_fraction;
  logic [encspi_pkg::BYTE_W-1:0]    register_value;
  logic                             alert_flag;
  logic [encspi_pkg::CNT_W-1:0]     failure_total;

  modport source (output valid, frame_ok, fault, position, turn_fraction, register_value,
                  alert_flag, failure_total, input ready);
  modport sink   (input valid, frame_ok, fault, position, turn_fraction, register_value,
                  alert_flag, failure_total, output ready);
endinterface

// ===== rtl/core/encspi_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on encspi_pkg for the index and data widths.

interface encspi_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [encspi_pkg::CFG_IDX_W-1:0]  index;
  logic [encspi_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/encspi_frame_check.sv =====
// Parity, CRC and device error checks on one response frame, and field unpacking.
// Depends on encspi_pkg for the check result type, fault codes and the CRC function.

module encspi_frame_check (
  input  logic                          kind,
  input  logic [encspi_pkg::BYTE_W-1:0] first_byte,
  input  logic [encspi_pkg::BYTE_W-1:0] second_byte,
  input  logic [encspi_pkg::BYTE_W-1:0] third_byte,
  input  logic                          frame_variant,
  output encspi_pkg::chk_t              chk
);

  logic       par16;
  logic       par23;
  logic [5:0] crc;

  // Parity over the 16-bit frame and over the 23 bits that the 24-bit parity bit covers.
  assign par16 = ^{first_byte, second_byte};
  assign par23 = ^{first_byte[6:0], second_byte, third_byte};
  assign crc   = encspi_pkg::crc6_byte(first_byte);

  // Check order follows the frame format: integrity first, then the device error bit.
  always_comb begin
    chk                = '0;
    chk.fault          = encspi_pkg::FAULT_NONE;
    if (kind == encspi_pkg::KIND_POSITION) begin
      chk.alert_flag = first_byte[6];
      if (frame_variant == encspi_pkg::VARIANT_16) begin
        if (par16) begin
          chk.fault = encspi_pkg::FAULT_PARITY;
        end else begin
          chk.raw_pos  = {4'b0000, first_byte[5:0], second_byte};
          chk.frame_ok = 1'b1;
        end
      end else begin
        if (par23 != first_byte[7]) begin
          chk.fault = encspi_pkg::FAULT_PARITY;
        end else if (first_byte[5]) begin
          chk.fault = encspi_pkg::FAULT_DEVICE;
        end else begin
          chk.raw_pos  = {first_byte[4:0], second_byte, third_byte[7:3]};
          chk.frame_ok = 1'b1;
        end
      end
      chk.pos_ok     = chk.frame_ok;
      chk.count_fail = ~chk.frame_ok;
    end else begin
      if (frame_variant == encspi_pkg::VARIANT_24) begin
        chk.alert_flag = second_byte[7];
        if (crc != second_byte[5:0]) begin
          chk.fault      = encspi_pkg::FAULT_CRC;
          chk.count_fail = 1'b1;
        end else if (second_byte[6]) begin
          chk.fault      = encspi_pkg::FAULT_DEVICE;
          chk.count_fail = 1'b1;
        end else begin
          chk.frame_ok = 1'b1;
        end
      end else begin
        // A parity failure on a 16-bit register frame is reported but not counted.
        if (par16) begin
          chk.fault = encspi_pkg::FAULT_PARITY;
        end else begin
          chk.frame_ok = 1'b1;
        end
      end
      chk.register_value = chk.frame_ok ? first_byte : '0;
    end
  end

endmodule

// ===== rtl/core/encspi_pos_scale.sv =====
// Masks the unpacked position to the kept resolution and forms the Q0.18 turn fraction.
// Depends on encspi_pkg for widths.

module encspi_pos_scale #(
  parameter int unsigned FULL_POSITION_BITS = 18
) (
  input  logic                              pos_ok,
  input  logic [encspi_pkg::FRAC_BITS-1:0]  raw_pos,
  input  logic [encspi_pkg::DROP_W-1:0]     resolution_drop,
  output logic [encspi_pkg::FRAC_BITS-1:0]  position,
  output logic [encspi_pkg::FRAC_BITS-1:0]  turn_fraction
);

  localparam logic [encspi_pkg::KEPT_W-1:0] FULL_W = encspi_pkg::KEPT_W'(FULL_POSITION_BITS);
  localparam logic [encspi_pkg::KEPT_W-1:0] FRAC_W = encspi_pkg::KEPT_W'(encspi_pkg::FRAC_BITS);

  logic [encspi_pkg::KEPT_W-1:0]    drop_ext;
  logic [encspi_pkg::KEPT_W-1:0]    kept;
  logic [encspi_pkg::KEPT_W-1:0]    shift;
  logic [encspi_pkg::FRAC_BITS-1:0] mask;
  logic [encspi_pkg::FRAC_BITS-1:0] masked;

  // Kept width is zero once the drop reaches the full position width.
  assign drop_ext = {1'b0, resolution_drop};
  assign kept     = (drop_ext < FULL_W) ? (FULL_W - drop_ext) : '0;
  assign shift    = FRAC_W - kept;

  // A shift of the full width leaves an empty mask for a kept width of zero.
  assign mask   = {encspi_pkg::FRAC_BITS{1'b1}} >> shift;
  assign masked = raw_pos & mask;

  assign position      = pos_ok ? masked : '0;
  assign turn_fraction = pos_ok ? (masked << shift) : '0;

endmodule

// ===== rtl/core/encspi_fail_count.sv =====
// Saturating 16-bit count of counted frame failures.
// Depends on encspi_pkg for the counter width and its saturation value.

module encspi_fail_count (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic                         count_fail,
  output logic [encspi_pkg::CNT_W-1:0] count,
  output logic [encspi_pkg::CNT_W-1:0] count_nxt
);

  logic [encspi_pkg::CNT_W-1:0] cnt_r;

  // Next value as seen by the word now leaving the input register.
  assign count_nxt = (count_fail && (cnt_r != encspi_pkg::CNT_MAX)) ?
                     (cnt_r + encspi_pkg::CNT_W'(1)) : cnt_r;
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (advance) begin
      cnt_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/encoder_spi_response_checker_top.sv =====
// Top level of the encoder SPI response checker: input register, checks, result register.
// Depends on encspi_pkg, the three channel interfaces and the check, scale and count modules.

// The block takes one three-byte response frame per word and returns one result word for
// it from its result register. A new frame may be taken in every cycle while the output
// is not stalled: the frame sits in an input register, is checked and unpacked by shallow
// parity, CRC and masking logic, and lands in a result register, so throughput is one
// word per cycle and is set only by these two register stages and the downstream ready.
// Configuration writes are always accepted and must be made while no frame is in flight.
// The failure total in each result is the saturating count after that frame.

module encoder_spi_response_checker_top #(
  parameter int unsigned FULL_POSITION_BITS = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  encspi_in_if.sink         in_ch,
  encspi_out_if.source      out_ch,
  encspi_cfg_if.sink        cfg_ch
);

  logic                              variant_r;
  logic [encspi_pkg::DROP_W-1:0]     drop_r;

  logic                              s1_v_r;
  logic                              s1_kind_r;
  logic [encspi_pkg::BYTE_W-1:0]     s1_b0_r;
  logic [encspi_pkg::BYTE_W-1:0]     s1_b1_r;
  logic [encspi_pkg::BYTE_W-1:0]     s1_b2_r;

  logic                              out_v_r;
  encspi_pkg::res_t                  res_r;
  encspi_pkg::res_t                  res_nxt;

  logic                              s2_rdy;
  logic                              s1_adv;
  logic                              in_take;
  encspi_pkg::chk_t                  chk;
  logic [encspi_pkg::FRAC_BITS-1:0]  position;
  logic [encspi_pkg::FRAC_BITS-1:0]  turn_fraction;
  logic [encspi_pkg::CNT_W-1:0]      cnt;
  logic [encspi_pkg::CNT_W-1:0]      cnt_nxt;

  // Handshake: each stage moves on when the stage after it is empty or draining.
  assign s2_rdy       = !out_v_r || out_ch.ready;
  assign s1_adv       = s1_v_r && s2_rdy;
  assign in_ch.ready  = !s1_v_r || s2_rdy;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Configuration registers and pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= encspi_pkg::VARIANT_16;
      drop_r    <= '0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          encspi_pkg::REG_FRAME_VARIANT:   variant_r <= cfg_ch.data[0];
          encspi_pkg::REG_RESOLUTION_DROP: drop_r    <= cfg_ch.data[encspi_pkg::DROP_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (s2_rdy) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r <= in_ch.kind;
      s1_b0_r   <= in_ch.first_byte;
      s1_b1_r   <= in_ch.second_byte;
      s1_b2_r   <= in_ch.third_byte;
    end
  end

  encspi_frame_check u_check (
    .kind          (s1_kind_r),
    .first_byte    (s1_b0_r),
    .second_byte   (s1_b1_r),
    .third_byte    (s1_b2_r),
    .frame_variant (variant_r),
    .chk           (chk)
  );

  encspi_pos_scale #(
    .FULL_POSITION_BITS (FULL_POSITION_BITS)
  ) u_scale (
    .pos_ok          (chk.pos_ok),
    .raw_pos         (chk.raw_pos),
    .resolution_drop (drop_r),
    .position        (position),
    .turn_fraction   (turn_fraction)
  );

  encspi_fail_count u_count (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (s1_adv),
    .count_fail (chk.count_fail),
    .count      (cnt),
    .count_nxt  (cnt_nxt)
  );

  // Result word assembled from the check, the scaler and the updated count.
  always_comb begin
    res_nxt.frame_ok       = chk.frame_ok;
    res_nxt.fault          = chk.fault;
    res_nxt.position       = position;
    res_nxt.turn_fraction  = turn_fraction;
    res_nxt.register_value = chk.register_value;
    res_nxt.alert_flag     = chk.alert_flag;
    res_nxt.failure_total  = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.frame_ok       = res_r.frame_ok;
  assign out_ch.fault          = res_r.fault;
  assign out_ch.position       = res_r.position;
  assign out_ch.turn_fraction  = res_r.turn_fraction;
  assign out_ch.register_value = res_r.register_value;
  assign out_ch.alert_flag     = res_r.alert_flag;
  assign out_ch.failure_total  = res_r.failure_total;

  // The count moves by at most one per cycle.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (cnt == $past(cnt)) || (cnt == $past(cnt) + encspi_pkg::CNT_W'(1)))
    else $error("failure count jumped by more than one");

  // A counted failure leaving the input register raises the count unless saturated.
  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && chk.count_fail && (cnt != encspi_pkg::CNT_MAX))
      |=> (cnt == $past(cnt) + encspi_pkg::CNT_W'(1)))
    else $error("counted failure did not advance the count");

  // A saturated count stays saturated.
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt == encspi_pkg::CNT_MAX) |=> (cnt == encspi_pkg::CNT_MAX))
    else $error("saturated failure count changed");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the encoder SPI response checker: random and directed frames
// against an in-line predictor of the checks, the unpacking and the failure count.
// Depends on encspi_pkg, the three channel interfaces and encoder_spi_response_checker_top.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One received frame as handed to the input channel.
  typedef struct packed {
    logic                          kind;
    logic [encspi_pkg::BYTE_W-1:0] b0;
    logic [encspi_pkg::BYTE_W-1:0] b1;
    logic [encspi_pkg::BYTE_W-1:0] b2;
  } frame_t;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned RANDOM_PHASES = 9;
  localparam int unsigned PHASE_WORDS   = 195;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned FULL_BITS     = 18;
  // Bit masks over the three frame bytes taken as one 24-bit word.
  localparam logic [23:0] PARITY_BIT    = 24'h800000;
  localparam logic [23:0] SECOND_LSB    = 24'h000100;

  logic clk;
  logic rst_n;

  encspi_in_if  in_ch();
  encspi_out_if out_ch();
  encspi_cfg_if cfg_ch();

  encoder_spi_response_checker_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: register copies and the saturating failure count.
  logic                          cfg_variant;
  logic [encspi_pkg::DROP_W-1:0] cfg_drop;
  logic [encspi_pkg::CNT_W-1:0]  fail_count;

  frame_t            pending_frames[$];
  encspi_pkg::res_t  expected_results[$];
  logic              in_acc;
  int                errors;
  int unsigned       cycles = 0;
  int unsigned       send_gap_pct;
  int unsigned       recv_stall_pct;

  // CRC-6 of one data byte, shifting the byte out MSB first.
  function automatic logic [5:0] crc6_of_data(input logic [encspi_pkg::BYTE_W-1:0] d);
    logic [5:0]                    c;
    logic [encspi_pkg::BYTE_W-1:0] s;
    c = encspi_pkg::CRC6_INIT;
    s = d;
    repeat (encspi_pkg::BYTE_W) begin
      if (c[5] ^ s[encspi_pkg::BYTE_W-1]) begin
        c = (c << 1) ^ encspi_pkg::CRC6_POLY;
      end else begin
        c = c << 1;
      end
      s = s << 1;
    end
    return c;
  endfunction

  // Expected result of one accepted frame; advances the failure count.
  function automatic encspi_pkg::res_t predict_frame(input frame_t f);
    encspi_pkg::res_t                r;
    logic [encspi_pkg::FRAC_BITS-1:0] raw;
    logic [encspi_pkg::FRAC_BITS:0]   mask;
    int unsigned                      kept;
    logic                             counted;
    r       = '0;
    raw     = '0;
    counted = 1'b0;
    if (f.kind == encspi_pkg::KIND_POSITION) begin
      r.alert_flag = f.b0[6];
      if (cfg_variant == encspi_pkg::VARIANT_16) begin
        if (^{f.b0, f.b1}) begin
          r.fault = encspi_pkg::FAULT_PARITY;
        end else begin
          raw        = {4'b0, f.b0[5:0], f.b1};
          r.frame_ok = 1'b1;
        end
      end else begin
        if ((^{f.b0[6:0], f.b1, f.b2}) != f.b0[7]) begin
          r.fault = encspi_pkg::FAULT_PARITY;
        end else if (f.b0[5]) begin
          r.fault = encspi_pkg::FAULT_DEVICE;
        end else begin
          raw        = {f.b0[4:0], f.b1, f.b2[7:3]};
          r.frame_ok = 1'b1;
        end
      end
      // Mask to the kept width, then left-align as a fraction of a turn.
      if (r.frame_ok) begin
        kept = (cfg_drop < FULL_BITS) ? FULL_BITS - cfg_drop : 0;
        if (kept != 0) begin
          mask            = (19'd1 << kept) - 19'd1;
          r.position      = raw & mask[encspi_pkg::FRAC_BITS-1:0];
          r.turn_fraction = r.position << (encspi_pkg::FRAC_BITS - kept);
        end
      end else begin
        counted = 1'b1;
      end
    end else begin
      if (cfg_variant == encspi_pkg::VARIANT_24) begin
        r.alert_flag = f.b1[7];
        // The CRC is judged before the device error bit.
        if (crc6_of_data(f.b0) != f.b1[5:0]) begin
          r.fault = encspi_pkg::FAULT_CRC;
          counted = 1'b1;
        end else if (f.b1[6]) begin
          r.fault = encspi_pkg::FAULT_DEVICE;
          counted = 1'b1;
        end else begin
          r.frame_ok = 1'b1;
        end
      end else if (^{f.b0, f.b1}) begin
        // A parity failure of a 16-bit register frame is reported but never counted.
        r.fault = encspi_pkg::FAULT_PARITY;
      end else begin
        r.frame_ok = 1'b1;
      end
      if (r.frame_ok) begin
        r.register_value = f.b0;
      end
    end
    if (counted && fail_count != encspi_pkg::CNT_MAX) begin
      fail_count = fail_count + encspi_pkg::CNT_W'(1);
    end
    r.failure_total = fail_count;
    return r;
  endfunction

  // Well-formed frames of each layout, with correct parity or CRC.
  function automatic frame_t pos16_frame(input logic [13:0] p, input logic ef);
    frame_t f;
    f.kind  = encspi_pkg::KIND_POSITION;
    f.b0    = {1'b0, ef, p[13:8]};
    f.b1    = p[7:0];
    f.b2    = 8'($urandom);
    f.b0[7] = ^{f.b0[6:0], f.b1};
    return f;
  endfunction

  function automatic frame_t pos24_frame(input logic [17:0] p, input logic w, input logic e);
    frame_t f;
    f.kind  = encspi_pkg::KIND_POSITION;
    f.b0    = {1'b0, w, e, p[17:13]};
    f.b1    = p[12:5];
    f.b2    = {p[4:0], 3'($urandom)};
    f.b0[7] = ^{f.b0[6:0], f.b1, f.b2};
    return f;
  endfunction

  function automatic frame_t reg24_frame(input logic [7:0] d, input logic w, input logic e);
    frame_t f;
    f.kind = encspi_pkg::KIND_REGISTER;
    f.b0   = d;
    f.b1   = {w, e, crc6_of_data(d)};
    f.b2   = 8'($urandom);
    return f;
  endfunction

  function automatic frame_t reg16_frame(input logic [7:0] d);
    frame_t f;
    f.kind  = encspi_pkg::KIND_REGISTER;
    f.b0    = d;
    f.b1    = 8'($urandom);
    f.b1[0] = ^{d, f.b1[7:1]};
    f.b2    = 8'($urandom);
    return f;
  endfunction

  function automatic frame_t flip_bits(input frame_t f, input logic [23:0] m);
    {f.b0, f.b1, f.b2} = {f.b0, f.b1, f.b2} ^ m;
    return f;
  endfunction

  // Mostly well-formed frames for the current variant, some with one bit broken,
  // the rest raw noise. Values lean towards the extremes now and then.
  function automatic frame_t random_frame();
    frame_t          f;
    int unsigned     sel;
    logic [17:0]     v;
    logic            w;
    logic            e;
    sel = $urandom_range(99);
    w   = 1'($urandom);
    e   = ($urandom_range(99) < 15);
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = '1;
      default: v = 18'($urandom);
    endcase
    if (cfg_variant == encspi_pkg::VARIANT_16) begin
      f = $urandom_range(1) ? reg16_frame(v[7:0]) : pos16_frame(v[13:0], w);
    end else begin
      f = $urandom_range(1) ? reg24_frame(v[7:0], w, e) : pos24_frame(v, w, e);
    end
    if (sel >= 85) begin
      f = frame_t'({1'($urandom), 24'($urandom)});
    end else if (sel >= 70) begin
      f = flip_bits(f, 24'h1 << $urandom_range(23));
    end
    return f;
  endfunction

  task automatic write_reg(input logic [encspi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [encspi_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == encspi_pkg::REG_FRAME_VARIANT) begin
      cfg_variant = val[0];
    end else begin
      cfg_drop = val[encspi_pkg::DROP_W-1:0];
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every frame has been taken and every expected word has come back.
  // Checked at the rising edge, where the driver's queue and valid are settled.
  task automatic drain();
    do @(posedge clk);
    while (pending_frames.size() != 0 || in_ch.valid || expected_results.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Frame driver: offers the next pending frame once the current one is taken.
  always @(negedge clk) begin : drive_frames
    frame_t f;
    if (rst_n && (!in_ch.valid || in_acc)) begin
      if (pending_frames.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        f = pending_frames.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= f.kind;
        in_ch.first_byte  <= f.b0;
        in_ch.second_byte <= f.b1;
        in_ch.third_byte  <= f.b2;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure.
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predicts each accepted frame and checks each accepted result word.
  always @(posedge clk) begin : watch_words
    encspi_pkg::res_t want;
    in_acc <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_results.push_back(predict_frame(frame_t'({in_ch.kind, in_ch.first_byte,
                                                          in_ch.second_byte,
                                                          in_ch.third_byte})));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word arrived with no expectation pending");
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("frame_ok", 32'(want.frame_ok), 32'(out_ch.frame_ok));
        check_field("fault", 32'(want.fault), 32'(out_ch.fault));
        check_field("position", 32'(want.position), 32'(out_ch.position));
        check_field("turn_fraction", 32'(want.turn_fraction), 32'(out_ch.turn_fraction));
        check_field("register_value", 32'(want.register_value),
                    32'(out_ch.register_value));
        check_field("alert_flag", 32'(want.alert_flag), 32'(out_ch.alert_flag));
        check_field("failure_total", 32'(want.failure_total), 32'(out_ch.failure_total));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_drop [RANDOM_PHASES] = '{0, 8, 8, 0, 3, 5, 0, 8, 6};
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = encspi_pkg::KIND_POSITION;
    in_ch.first_byte   = '0;
    in_ch.second_byte  = '0;
    in_ch.third_byte   = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = encspi_pkg::REG_FRAME_VARIANT;
    cfg_ch.data        = '0;
    in_acc             = 1'b0;
    cfg_variant        = encspi_pkg::VARIANT_16;
    cfg_drop           = '0;
    fail_count         = '0;
    errors             = 0;
    send_gap_pct       = 32;
    recv_stall_pct     = 84;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed 16-bit frames: extremes, the EF flag, and uncounted register parity failures.
    write_reg(encspi_pkg::REG_FRAME_VARIANT, encspi_pkg::CFG_DATA_W'(encspi_pkg::VARIANT_16));
    write_reg(encspi_pkg::REG_RESOLUTION_DROP, 8'd0);
    pending_frames.push_back(pos16_frame(14'h0000, 1'b0));
    pending_frames.push_back(pos16_frame(14'h3FFF, 1'b1));
    pending_frames.push_back(pos16_frame(14'h2AAA, 1'b0));
    pending_frames.push_back(flip_bits(pos16_frame(14'h1555, 1'b1), PARITY_BIT));
    pending_frames.push_back(frame_t'({encspi_pkg::KIND_POSITION, 24'hFFFFFF}));
    pending_frames.push_back(reg16_frame(8'h00));
    pending_frames.push_back(reg16_frame(8'hFF));
    pending_frames.push_back(flip_bits(reg16_frame(8'hA5), SECOND_LSB));
    pending_frames.push_back(frame_t'({encspi_pkg::KIND_REGISTER, 24'hFFFE00}));
    drain();

    // Directed 24-bit frames: parity before the E bit, CRC before the E bit, W reported.
    write_reg(encspi_pkg::REG_FRAME_VARIANT, encspi_pkg::CFG_DATA_W'(encspi_pkg::VARIANT_24));
    pending_frames.push_back(pos24_frame(18'h00000, 1'b0, 1'b0));
    pending_frames.push_back(pos24_frame(18'h3FFFF, 1'b1, 1'b0));
    pending_frames.push_back(pos24_frame(18'h3FFFF, 1'b0, 1'b1));
    pending_frames.push_back(flip_bits(pos24_frame(18'h12345, 1'b0, 1'b0), PARITY_BIT));
    pending_frames.push_back(flip_bits(pos24_frame(18'h00000, 1'b0, 1'b1), PARITY_BIT));
    pending_frames.push_back(reg24_frame(8'h00, 1'b0, 1'b0));
    pending_frames.push_back(reg24_frame(8'hFF, 1'b1, 1'b0));
    pending_frames.push_back(reg24_frame(8'h5A, 1'b0, 1'b1));
    pending_frames.push_back(flip_bits(reg24_frame(8'hC3, 1'b0, 1'b0), SECOND_LSB));
    pending_frames.push_back(flip_bits(reg24_frame(8'h3C, 1'b1, 1'b1), SECOND_LSB));
    pending_frames.push_back(frame_t'({encspi_pkg::KIND_POSITION, 24'hFFFFFF}));
    drain();

    // Random phases over both variants and several resolutions at three idling levels.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 3) begin
        send_gap_pct   = 84;
        recv_stall_pct = 32;
      end else if (p == 6) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      write_reg(encspi_pkg::REG_FRAME_VARIANT, encspi_pkg::CFG_DATA_W'(p % 2));
      write_reg(encspi_pkg::REG_RESOLUTION_DROP, encspi_pkg::CFG_DATA_W'(phase_drop[p]));
      for (int unsigned i = 0; i < PHASE_WORDS; i++) begin
        pending_frames.push_back(random_frame());
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected result words never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
